[src/bmq_pkg.sv]
// Package for the balanced multi-queue unit.
// Holds default sizes, operation kinds and status codes.
// No dependencies.
package bmq_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int WORD_W          = 32;
  localparam int STATUS_W        = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

[src/bmq_select.sv]
// Queue selection tree: picks the shortest queue for an enqueue and the
// longest queue for a dequeue, lowest index on a tie.
// Depends on bmq_pkg.
module bmq_select import bmq_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int COUNT_W    = $clog2(QUEUE_DEPTH_DEF + 1),
  localparam int IdxW      = $clog2(NUM_QUEUES)
) (
  input  logic               kind,
  input  logic [COUNT_W-1:0] counts [NUM_QUEUES],
  output logic [IdxW-1:0]    sel_idx,
  output logic [COUNT_W-1:0] sel_count
);

  localparam int Leaves = 1 << IdxW;

  logic [IdxW-1:0]    node_idx [1:2*Leaves-1];
  logic [COUNT_W-1:0] node_cnt [1:2*Leaves-1];
  logic               node_ok  [1:2*Leaves-1];

  always_comb begin
    logic take_right;
    take_right = 1'b0;
    for (int i = 0; i < Leaves; i++) begin
      node_idx[Leaves+i] = IdxW'(i);
      node_cnt[Leaves+i] = '0;
      node_ok[Leaves+i]  = 1'b0;
      if (i < NUM_QUEUES) begin
        node_cnt[Leaves+i] = counts[i];
        node_ok[Leaves+i]  = 1'b1;
      end
    end
    for (int k = Leaves - 1; k >= 1; k--) begin
      if (kind == KIND_DEQ) begin
        take_right = node_ok[2*k+1] &&
                     (!node_ok[2*k] || (node_cnt[2*k+1] > node_cnt[2*k]));
      end else begin
        take_right = node_ok[2*k+1] &&
                     (!node_ok[2*k] || (node_cnt[2*k+1] < node_cnt[2*k]));
      end
      node_idx[k] = take_right ? node_idx[2*k+1] : node_idx[2*k];
      node_cnt[k] = take_right ? node_cnt[2*k+1] : node_cnt[2*k];
      node_ok[k]  = node_ok[2*k] || node_ok[2*k+1];
    end
    sel_idx   = node_idx[1];
    sel_count = node_cnt[1];
  end

endmodule

[src/balanced_multi_queue_unit.sv]
// Balanced multi-queue unit: several FIFOs in one shared entry memory.
// An accepted word goes through the pending register and then the output
// register; one word is accepted per cycle while in_stall is low, limited
// by the single port of the entry memory.
// Reset clears all counts and pointers; entry memory contents are not reset.
// Depends on bmq_pkg and bmq_select.
module balanced_multi_queue_unit import bmq_pkg::*; #(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int IdxW       = $clog2(NUM_QUEUES),
  localparam int CountW     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [WORD_W-1:0] in_value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IdxW-1:0]          out_queue_index,
  output logic signed [WORD_W-1:0] out_value_out,
  output logic [STATUS_W-1:0]      out_status,
  output logic [CountW-1:0]        out_count_after
);

  localparam int PtrW    = $clog2(QUEUE_DEPTH);
  localparam int Entries = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AddrW   = $clog2(Entries);

  logic [CountW-1:0] cnt_r  [NUM_QUEUES];
  logic [PtrW-1:0]   rptr_r [NUM_QUEUES];
  logic [PtrW-1:0]   wptr_r [NUM_QUEUES];

  logic [WORD_W-1:0] mem [Entries];
  logic [WORD_W-1:0] rdata_r;

  logic                p_valid_r;
  logic [IdxW-1:0]     p_idx_r;
  logic [STATUS_W-1:0] p_status_r;
  logic [CountW-1:0]   p_cnt_r;
  logic                p_rd_r;

  logic                out_valid_r;
  logic [IdxW-1:0]     out_idx_r;
  logic [WORD_W-1:0]   out_value_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CountW-1:0]   out_cnt_r;

  logic [IdxW-1:0]   sel_idx;
  logic [CountW-1:0] sel_count;
  logic              accept;
  logic              advance;
  logic              is_full;
  logic              is_empty;
  logic              wr_en;
  logic              rd_en;
  logic [PtrW-1:0]   ptr;
  logic [PtrW-1:0]   ptr_inc;
  logic [AddrW-1:0]  addr;
  logic [CountW-1:0] cnt_new;
  logic [STATUS_W-1:0] status_new;

  bmq_select #(
    .NUM_QUEUES(NUM_QUEUES),
    .COUNT_W   (CountW)
  ) u_select (
    .kind     (in_kind),
    .counts   (cnt_r),
    .sel_idx  (sel_idx),
    .sel_count(sel_count)
  );

  assign advance  = p_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = p_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign is_full  = (sel_count == CountW'(QUEUE_DEPTH));
  assign is_empty = (sel_count == '0);
  assign wr_en    = accept && (in_kind == KIND_ENQ) && !is_full;
  assign rd_en    = accept && (in_kind == KIND_DEQ) && !is_empty;

  always_comb begin
    ptr        = (in_kind == KIND_DEQ) ? rptr_r[sel_idx] : wptr_r[sel_idx];
    ptr_inc    = (ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PtrW'(1);
    addr       = AddrW'(sel_idx) * AddrW'(QUEUE_DEPTH) + AddrW'(ptr);
    cnt_new    = sel_count;
    status_new = STATUS_DONE;
    if (in_kind == KIND_ENQ) begin
      if (is_full) begin
        status_new = STATUS_FULL;
      end else begin
        cnt_new = sel_count + CountW'(1);
      end
    end else begin
      if (is_empty) begin
        status_new = STATUS_EMPTY;
      end else begin
        cnt_new = sel_count - CountW'(1);
      end
    end
  end

  // A dequeue only reads entries written at an earlier edge, so the
  // memory needs no forwarding.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= in_value_in;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_r[i]  <= '0;
        rptr_r[i] <= '0;
        wptr_r[i] <= '0;
      end
    end else if (wr_en || rd_en) begin
      cnt_r[sel_idx] <= cnt_new;
      if (wr_en) begin
        wptr_r[sel_idx] <= ptr_inc;
      end else begin
        rptr_r[sel_idx] <= ptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (advance) begin
        p_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_idx_r    <= sel_idx;
      p_status_r <= status_new;
      p_cnt_r    <= cnt_new;
      p_rd_r     <= rd_en;
    end
    if (advance) begin
      out_idx_r    <= p_idx_r;
      out_value_r  <= p_rd_r ? rdata_r : '0;
      out_status_r <= p_status_r;
      out_cnt_r    <= p_cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_queue_index = out_idx_r;
  assign out_value_out   = out_value_r;
  assign out_status      = out_status_r;
  assign out_count_after = out_cnt_r;

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EMPTY |->
      out_count_after == '0 && out_queue_index == '0)
    else $error("empty result must name queue zero with a zero count");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |->
      out_count_after == CountW'(QUEUE_DEPTH))
    else $error("full result must report a full queue");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_DONE |-> out_value_out == '0)
    else $error("refused request must return a zero word");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> p_valid_r)
    else $error("accepted word lost before the output stage");

endmodule

[test/bmq_checker.sv]
// Checker for the balanced multi-queue unit: it watches both channels, keeps its own
// copy of the queues, and compares each result word with the predicted one.
// Depends on bmq_pkg.
module bmq_checker import bmq_pkg::*; #(
  parameter int NQ    = NUM_QUEUES_DEF,
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int IdxW   = $clog2(NQ),
  localparam int CountW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [WORD_W-1:0] in_value_in,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [IdxW-1:0]          out_queue_index,
  input  logic signed [WORD_W-1:0] out_value_out,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic [CountW-1:0]        out_count_after,
  output int                       errors,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdxW-1:0]          queue;
    logic signed [WORD_W-1:0] word;
    logic [STATUS_W-1:0]      status;
    logic [CountW-1:0]        count;
  } outcome_t;

  outcome_t                 queued_outcomes[$];
  outcome_t                 want;
  logic signed [WORD_W-1:0] slots[NQ][DEPTH];
  int                       fill[NQ];
  int                       rd_ptr[NQ];
  int                       wr_ptr[NQ];
  int                       fails = 0;

  assign errors      = fails;
  assign outstanding = queued_outcomes.size();

  function automatic outcome_t balance_request(logic kind, logic signed [WORD_W-1:0] word);
    outcome_t r;
    int       q;
    r = '0;
    q = 0;
    if (kind == KIND_ENQ) begin
      for (int i = 1; i < NQ; i++) if (fill[i] < fill[q]) q = i;
      if (fill[q] >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        slots[q][wr_ptr[q]] = word;
        wr_ptr[q] = (wr_ptr[q] + 1) % DEPTH;
        fill[q]++;
        r.status = STATUS_DONE;
      end
    end else begin
      for (int i = 1; i < NQ; i++) if (fill[i] > fill[q]) q = i;
      if (fill[q] == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.word = slots[q][rd_ptr[q]];
        rd_ptr[q] = (rd_ptr[q] + 1) % DEPTH;
        fill[q]--;
        r.status = STATUS_DONE;
      end
    end
    r.queue = q;
    r.count = fill[q];
    return r;
  endfunction

  task automatic compare_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        fill[i] = 0;
        rd_ptr[i] = 0;
        wr_ptr[i] = 0;
      end
      queued_outcomes.delete();
    end else begin
      if (in_valid && !in_stall) queued_outcomes.push_back(balance_request(in_kind, in_value_in));
      if (out_valid && !out_stall) begin
        if (queued_outcomes.size() == 0) begin
          $display("%0t ns: result word with none expected, actual queue %0d value %0d",
                   $time, out_queue_index, out_value_out);
          fails++;
        end else begin
          want = queued_outcomes.pop_front();
          compare_field("queue_index", want.queue, out_queue_index);
          compare_field("value_out", want.word, out_value_out);
          compare_field("status", want.status, out_status);
          compare_field("count_after", want.count, out_count_after);
        end
      end
    end
  end

endmodule

[test/balanced_multi_queue_unit_tb.sv]
// Testbench top for the balanced multi-queue unit: drives enqueue and dequeue
// words with random gaps and output stalls, and gives the verdict.
// Depends on bmq_pkg, balanced_multi_queue_unit and bmq_checker.
module balanced_multi_queue_unit_tb import bmq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ     = NUM_QUEUES_DEF;
  localparam int DEPTH  = QUEUE_DEPTH_DEF;
  localparam int IdxW   = $clog2(NQ);
  localparam int CountW = $clog2(DEPTH + 1);
  localparam int RANDOM_WORDS = 1400;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_kind = KIND_ENQ;
  logic signed [WORD_W-1:0] in_value_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IdxW-1:0]          out_queue_index;
  logic signed [WORD_W-1:0] out_value_out;
  logic [STATUS_W-1:0]      out_status;
  logic [CountW-1:0]        out_count_after;
  int                       errors;
  int                       outstanding;
  bit                       sender_gaps = 1'b1;

  always #1 clk = ~clk;

  balanced_multi_queue_unit #(.NUM_QUEUES(NQ), .QUEUE_DEPTH(DEPTH)) dut (.*);

  bmq_checker #(.NQ(NQ), .DEPTH(DEPTH)) u_checker (.*);

  task automatic send_word(logic kind, logic signed [WORD_W-1:0] value);
    while (sender_gaps && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_value_in <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // The receiver holds off for a long stretch early on so that the unit fills up,
  // and later stays ready for a while.
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (rst_n) cyc++;
      if (!rst_n) out_stall <= 1'b0;
      else if (cyc >= 300 && cyc < 420) out_stall <= 1'b1;
      else if (cyc >= 1500 && cyc < 1900) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 36);
    end
  end

  initial begin
    int phase_left;
    int enq_pct;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_word(KIND_DEQ, $urandom());
    send_word(KIND_ENQ, 32'sh7FFF_FFFF);
    send_word(KIND_ENQ, 32'sh8000_0000);
    send_word(KIND_ENQ, 32'sh0000_0000);
    send_word(KIND_ENQ, 32'shFFFF_FFFF);
    send_word(KIND_ENQ, 32'sh5555_5555);
    send_word(KIND_ENQ, 32'shAAAA_AAAA);
    repeat (7) send_word(KIND_DEQ, $urandom());
    send_word(KIND_DEQ, 32'shFFFF_FFFF);
    send_word(KIND_ENQ, 32'sh0000_0001);
    send_word(KIND_DEQ, 32'sh0000_0000);

    // Random phases lean toward filling or draining so that every queue reaches
    // both full and empty, and the pointers wrap many times.
    phase_left = 0;
    enq_pct = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(2))
          0: enq_pct = 88;
          1: enq_pct = 12;
          default: enq_pct = 50;
        endcase
      end
      phase_left--;
      sender_gaps = !(n >= 900 && n < 1100);
      send_word(($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ, $urandom());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
